// File: sv/fprc_pkg.sv
// fprc_pkg: shared constants, codes and types of the fan and pump relay controller
// no dependencies; used by fprc_div and fan_pump_relay_controller

package fprc_pkg;

   // widths
   localparam int TIMER_BITS = 32;
   localparam int ADC_BITS   = 12;
   localparam int CFG_BITS   = 32;
   localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
   localparam int TEMP_BITS  = 15;
   localparam int HYST_BITS  = 11;
   localparam int PCT_BITS   = 7;
   localparam int OP_BITS    = 3;
   localparam int IDX_BITS   = 3;
   localparam int EV_BITS    = 4;
   localparam int POL_BITS   = 2;

   // soil mapping: |raw - dry| * 100 needs seven more bits than the reading
   localparam int DIV_BITS = ADC_BITS + PCT_BITS;
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);
   localparam logic [PCT_BITS-1:0] PCT_MAX = PCT_BITS'(100);

   // item op codes
   localparam logic [OP_BITS-1:0] OP_TICK      = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SAMPLE    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_FAN_MAN   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_FAN_AUTO  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_PUMP_MAN  = 3'd4;
   localparam logic [OP_BITS-1:0] OP_PUMP_AUTO = 3'd5;

   // register indexes
   localparam logic [IDX_BITS-1:0] REG_FAN_THR   = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_FAN_HYST  = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_SOIL_THR  = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_SOIL_DRY  = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_SOIL_WET  = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_PUMP_MAX  = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_PUMP_COOL = 3'd6;
   localparam logic [IDX_BITS-1:0] REG_RELAY_POL = 3'd7;

   // register reset values
   localparam logic [TEMP_BITS-1:0] RST_FAN_THR   = 15'd3000;
   localparam logic [HYST_BITS-1:0] RST_FAN_HYST  = 11'd100;
   localparam logic [PCT_BITS-1:0]  RST_SOIL_THR  = 7'd30;
   localparam logic [ADC_BITS-1:0]  RST_SOIL_DRY  = ADC_BITS'(3000);
   localparam logic [ADC_BITS-1:0]  RST_SOIL_WET  = ADC_BITS'(1200);
   localparam logic [CFG_BITS-1:0]  RST_PUMP_MAX  = 32'd10000;
   localparam logic [CFG_BITS-1:0]  RST_PUMP_COOL = 32'd60000;
   localparam logic [POL_BITS-1:0]  RST_RELAY_POL = 2'd0;

   // event bit positions
   localparam int EV_FAN_ON   = 0;
   localparam int EV_FAN_OFF  = 1;
   localparam int EV_PUMP_ON  = 2;
   localparam int EV_PUMP_OFF = 3;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: sv/fprc_div.sv
// fprc_div: restoring divider, one quotient bit per cycle through one subtractor
// depends on fprc_pkg

module fprc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fprc_pkg::DIV_BITS-1:0]     dividend,
   input  logic [fprc_pkg::ADC_BITS-1:0]     divisor,
   output logic [fprc_pkg::DIV_BITS-1:0]     quotient,
   output fprc_pkg::div_status_type          status
);

   logic [fprc_pkg::ADC_BITS:0]   rem_ff, rem_in;
   logic [fprc_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [fprc_pkg::ADC_BITS-1:0] dvs_ff, dvs_in;
   logic [fprc_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [fprc_pkg::ADC_BITS:0]   shifted;
   logic [fprc_pkg::ADC_BITS:0]   trial;

   // one shift, compare and subtract step
   assign shifted = {rem_ff[fprc_pkg::ADC_BITS-1:0], quo_ff[fprc_pkg::DIV_BITS-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = fprc_pkg::CNT_BITS'(fprc_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial;
            quo_in = {quo_ff[fprc_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[fprc_pkg::DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == fprc_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // checks
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a preceding run");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while running");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0) && (cnt_ff <= fprc_pkg::CNT_BITS'(fprc_pkg::DIV_BITS)))
      else $error("divider step count out of range");

endmodule

// File: sv/fan_pump_relay_controller.sv
// fan_pump_relay_controller: thermostat fan and soil-driven pump relay control
// depends on fprc_pkg and fprc_div
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall| op, turn_on, temperature, soil_raw
//   rsp_    | out       | rsp_valid/rsp_stall| relay states, modes, levels, percent, events
//   csr_    | in        | csr_valid/csr_ready| register index, write data
//
// an item that needs the division passes the map, divide and execute states; any other
// item goes from map straight to execute; the next item is taken in idle once the result
// is registered; the bit-serial divider (one quotient bit a cycle) sets the divide length
// synchronous active-high reset; configuration registers return to their documented defaults
// the result register is separate, so a new item is taken while a result waits
// req_stall is high while an item is in work; csr_ready is always high

module fan_pump_relay_controller (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fprc_pkg::OP_BITS-1:0]        req_op,
   input  logic                                req_turn_on,
   input  logic signed [fprc_pkg::TEMP_BITS-1:0] req_temperature,
   input  logic [fprc_pkg::ADC_BITS-1:0]       req_soil_raw,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_fan_on,
   output logic                                rsp_pump_on,
   output logic                                rsp_fan_auto,
   output logic                                rsp_pump_auto,
   output logic                                rsp_fan_relay_level,
   output logic                                rsp_pump_relay_level,
   output logic [fprc_pkg::PCT_BITS-1:0]       rsp_soil_percent,
   output logic [fprc_pkg::EV_BITS-1:0]        rsp_events,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fprc_pkg::IDX_BITS-1:0]       csr_index,
   input  logic [fprc_pkg::CFG_BITS-1:0]       csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MAP  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_EXEC = 2'd3;

   // configuration registers
   logic signed [fprc_pkg::TEMP_BITS-1:0] fan_thr_ff;
   logic [fprc_pkg::HYST_BITS-1:0]        fan_hyst_ff;
   logic [fprc_pkg::PCT_BITS-1:0]         soil_thr_ff;
   logic [fprc_pkg::ADC_BITS-1:0]         soil_dry_ff;
   logic [fprc_pkg::ADC_BITS-1:0]         soil_wet_ff;
   logic [fprc_pkg::CFG_BITS-1:0]         pump_max_ff;
   logic [fprc_pkg::CFG_BITS-1:0]         pump_cool_ff;
   logic [fprc_pkg::POL_BITS-1:0]         relay_pol_ff;

   // controller state
   logic                            fan_state_ff, fan_state_in;
   logic                            fan_auto_ff, fan_auto_in;
   logic                            pump_state_ff, pump_state_in;
   logic                            pump_auto_ff, pump_auto_in;
   logic [fprc_pkg::TIMER_BITS-1:0] run_time_ff, run_time_in;
   logic [fprc_pkg::TIMER_BITS-1:0] since_start_ff, since_start_in;
   logic                            started_ff, started_in;

   // sequencer and captured item
   logic [1:0]                            state_ff, state_in;
   logic [fprc_pkg::OP_BITS-1:0]          op_ff;
   logic                                  turn_on_ff;
   logic signed [fprc_pkg::TEMP_BITS-1:0] temp_ff;
   logic [fprc_pkg::ADC_BITS-1:0]         raw_ff;
   logic [fprc_pkg::PCT_BITS-1:0]         pct_ff, pct_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_fan_ff, out_pump_ff, out_fan_auto_ff, out_pump_auto_ff;
   logic                          out_fan_lvl_ff, out_pump_lvl_ff;
   logic [fprc_pkg::PCT_BITS-1:0] out_pct_ff;
   logic [fprc_pkg::EV_BITS-1:0]  out_ev_ff;

   logic                          req_take;
   logic                          csr_take;
   logic                          load_out;
   logic                          rsp_take;

   // soil mapping operands
   logic signed [fprc_pkg::ADC_BITS:0] diff;
   logic signed [fprc_pkg::ADC_BITS:0] span;
   logic [fprc_pkg::ADC_BITS-1:0]      diff_mag;
   logic [fprc_pkg::ADC_BITS-1:0]      span_mag;
   logic [fprc_pkg::DIV_BITS-1:0]      diff_ext;
   logic [fprc_pkg::DIV_BITS-1:0]      scaled;
   logic                               has_reading;
   logic                               need_div;
   logic                               div_start;
   logic [fprc_pkg::DIV_BITS-1:0]      div_q;
   fprc_pkg::div_status_type           div_st;

   // item evaluation
   logic signed [fprc_pkg::TEMP_BITS:0] off_limit;
   logic                                fan_on_hit;
   logic                                fan_off_hit;
   logic                                cooling;
   logic                                pump_start;
   logic [fprc_pkg::TIMER_BITS-1:0]     run_inc;
   logic [fprc_pkg::TIMER_BITS-1:0]     since_inc;
   logic [fprc_pkg::EV_BITS-1:0]        ev;
   logic                                fan_tmp;

   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign load_out  = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != S_IDLE);

   // soil percent = (raw - dry) * 100 / (wet - dry), truncated and clamped
   assign diff     = $signed({1'b0, raw_ff}) - $signed({1'b0, soil_dry_ff});
   assign span     = $signed({1'b0, soil_wet_ff}) - $signed({1'b0, soil_dry_ff});
   assign diff_mag = diff[fprc_pkg::ADC_BITS] ? fprc_pkg::ADC_BITS'(-diff)
                                              : diff[fprc_pkg::ADC_BITS-1:0];
   assign span_mag = span[fprc_pkg::ADC_BITS] ? fprc_pkg::ADC_BITS'(-span)
                                              : span[fprc_pkg::ADC_BITS-1:0];
   assign diff_ext = fprc_pkg::DIV_BITS'(diff_mag);
   assign scaled   = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);

   assign has_reading = (op_ff >= fprc_pkg::OP_SAMPLE) && (op_ff <= fprc_pkg::OP_PUMP_AUTO);
   // a quotient of opposite sign or zero, or a zero span, clamps to zero
   assign need_div = has_reading && (span != '0) && (diff != '0)
                     && (diff[fprc_pkg::ADC_BITS] == span[fprc_pkg::ADC_BITS]);
   assign div_start = (state_ff == S_MAP) && need_div;

   fprc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scaled),
      .divisor  (span_mag),
      .quotient (div_q),
      .status   (div_st)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      pct_in   = pct_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_MAP;
         end
         S_MAP: begin
            pct_in = '0;
            if (need_div) state_in = S_DIV;
            else          state_in = S_EXEC;
         end
         S_DIV: begin
            if (div_st.done) begin
               if (div_q > fprc_pkg::DIV_BITS'(fprc_pkg::PCT_MAX)) pct_in = fprc_pkg::PCT_MAX;
               else pct_in = div_q[fprc_pkg::PCT_BITS-1:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (load_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // fan thresholds and pump start conditions
   assign off_limit  = $signed({fan_thr_ff[fprc_pkg::TEMP_BITS-1], fan_thr_ff})
                       - $signed({5'b0, fan_hyst_ff});
   assign fan_on_hit = (temp_ff >= fan_thr_ff);
   assign fan_off_hit = ($signed({temp_ff[fprc_pkg::TEMP_BITS-1], temp_ff}) <= off_limit);
   assign cooling    = started_ff && (fprc_pkg::CMP_BITS'(since_start_ff)
                                      < fprc_pkg::CMP_BITS'(pump_cool_ff));
   assign pump_start = !pump_state_ff && !cooling && (pct_ff < soil_thr_ff);
   assign run_inc    = (&run_time_ff) ? run_time_ff : run_time_ff + 1'b1;
   assign since_inc  = (&since_start_ff) ? since_start_ff : since_start_ff + 1'b1;

   // apply one item
   always_comb begin
      fan_state_in   = fan_state_ff;
      fan_auto_in    = fan_auto_ff;
      pump_state_in  = pump_state_ff;
      pump_auto_in   = pump_auto_ff;
      run_time_in    = run_time_ff;
      since_start_in = since_start_ff;
      started_in     = started_ff;
      ev             = '0;
      fan_tmp        = fan_state_ff;
      case (op_ff)
         fprc_pkg::OP_TICK: begin
            run_time_in    = run_inc;
            since_start_in = since_inc;
            if (pump_state_ff && (fprc_pkg::CMP_BITS'(run_inc)
                                  >= fprc_pkg::CMP_BITS'(pump_max_ff))) begin
               pump_state_in = 1'b0;
               ev[fprc_pkg::EV_PUMP_OFF] = 1'b1;
            end
         end
         fprc_pkg::OP_FAN_MAN: begin
            fan_auto_in  = 1'b0;
            fan_state_in = turn_on_ff;
         end
         fprc_pkg::OP_PUMP_MAN: begin
            pump_auto_in  = 1'b0;
            pump_state_in = turn_on_ff;
            if (turn_on_ff) run_time_in = '0;
         end
         fprc_pkg::OP_SAMPLE, fprc_pkg::OP_FAN_AUTO, fprc_pkg::OP_PUMP_AUTO: begin
            if (op_ff == fprc_pkg::OP_FAN_AUTO)  fan_auto_in  = 1'b1;
            if (op_ff == fprc_pkg::OP_PUMP_AUTO) pump_auto_in = 1'b1;
            // fan: on check first, then off check on the new state
            if (op_ff != fprc_pkg::OP_PUMP_AUTO && fan_auto_in) begin
               if (!fan_tmp && fan_on_hit) begin
                  fan_tmp = 1'b1;
                  ev[fprc_pkg::EV_FAN_ON] = 1'b1;
               end
               if (fan_tmp && fan_off_hit) begin
                  fan_tmp = 1'b0;
                  ev[fprc_pkg::EV_FAN_OFF] = 1'b1;
               end
               fan_state_in = fan_tmp;
            end
            // pump: automatic start outside the cooldown
            if (op_ff != fprc_pkg::OP_FAN_AUTO && pump_auto_in && pump_start) begin
               pump_state_in  = 1'b1;
               run_time_in    = '0;
               since_start_in = '0;
               started_in     = 1'b1;
               ev[fprc_pkg::EV_PUMP_ON] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) rsp_valid_in = 1'b0;
      if (load_out) rsp_valid_in = 1'b1;
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         fan_state_ff   <= 1'b0;
         fan_auto_ff    <= 1'b0;
         pump_state_ff  <= 1'b0;
         pump_auto_ff   <= 1'b1;
         run_time_ff    <= '0;
         since_start_ff <= '0;
         started_ff     <= 1'b0;
         fan_thr_ff     <= fprc_pkg::RST_FAN_THR;
         fan_hyst_ff    <= fprc_pkg::RST_FAN_HYST;
         soil_thr_ff    <= fprc_pkg::RST_SOIL_THR;
         soil_dry_ff    <= fprc_pkg::RST_SOIL_DRY;
         soil_wet_ff    <= fprc_pkg::RST_SOIL_WET;
         pump_max_ff    <= fprc_pkg::RST_PUMP_MAX;
         pump_cool_ff   <= fprc_pkg::RST_PUMP_COOL;
         relay_pol_ff   <= fprc_pkg::RST_RELAY_POL;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_out) begin
            fan_state_ff   <= fan_state_in;
            fan_auto_ff    <= fan_auto_in;
            pump_state_ff  <= pump_state_in;
            pump_auto_ff   <= pump_auto_in;
            run_time_ff    <= run_time_in;
            since_start_ff <= since_start_in;
            started_ff     <= started_in;
         end
         if (csr_take) begin
            case (csr_index)
               fprc_pkg::REG_FAN_THR:   fan_thr_ff   <= csr_data[fprc_pkg::TEMP_BITS-1:0];
               fprc_pkg::REG_FAN_HYST:  fan_hyst_ff  <= csr_data[fprc_pkg::HYST_BITS-1:0];
               fprc_pkg::REG_SOIL_THR:  soil_thr_ff  <= csr_data[fprc_pkg::PCT_BITS-1:0];
               fprc_pkg::REG_SOIL_DRY:  soil_dry_ff  <= csr_data[fprc_pkg::ADC_BITS-1:0];
               fprc_pkg::REG_SOIL_WET:  soil_wet_ff  <= csr_data[fprc_pkg::ADC_BITS-1:0];
               fprc_pkg::REG_PUMP_MAX:  pump_max_ff  <= csr_data;
               fprc_pkg::REG_PUMP_COOL: pump_cool_ff <= csr_data;
               fprc_pkg::REG_RELAY_POL: relay_pol_ff <= csr_data[fprc_pkg::POL_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // captured item, percent and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= req_op;
         turn_on_ff <= req_turn_on;
         temp_ff    <= req_temperature;
         raw_ff     <= req_soil_raw;
      end
      pct_ff <= pct_in;
      if (load_out) begin
         out_fan_ff       <= fan_state_in;
         out_pump_ff      <= pump_state_in;
         out_fan_auto_ff  <= fan_auto_in;
         out_pump_auto_ff <= pump_auto_in;
         out_fan_lvl_ff   <= fan_state_in ^ relay_pol_ff[0];
         out_pump_lvl_ff  <= pump_state_in ^ relay_pol_ff[1];
         out_pct_ff       <= pct_ff;
         out_ev_ff        <= ev;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fan_on           = out_fan_ff;
   assign rsp_pump_on          = out_pump_ff;
   assign rsp_fan_auto         = out_fan_auto_ff;
   assign rsp_pump_auto        = out_pump_auto_ff;
   assign rsp_fan_relay_level  = out_fan_lvl_ff;
   assign rsp_pump_relay_level = out_pump_lvl_ff;
   assign rsp_soil_percent     = out_pct_ff;
   assign rsp_events           = out_ev_ff;

   // checks
   a_start_to_div: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == S_DIV) && div_st.busy)
      else $error("divider start did not enter the division state");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_st.busy || div_st.done))
      else $error("waiting on a divider that is not running");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_pct_ff <= fprc_pkg::PCT_MAX))
      else $error("soil percent above one hundred");

   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("result load did not complete the item");

endmodule
